// File: rtl/assert_macros.svh
// Assertion macros used by the controller (mau_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// File: rtl/mau_pkg.sv
// Package with types and constants of the modular arithmetic unit
`timescale 1ns / 1ps
package mau_pkg;

  localparam int unsigned ModW = 31;
  localparam int unsigned ValW = 30;
  localparam int unsigned ExpW = 63;
  localparam int unsigned OpW = 3;
  localparam int unsigned CntW = 5;
  localparam logic [CntW-1:0] LastStep = 5'd30;
  localparam logic [ModW-1:0] ModReset = 31'd998244353;
  localparam logic [ModW-1:0] ModMax = 31'd1073741824;

  localparam logic [OpW-1:0] OP_ADD = 3'd0;
  localparam logic [OpW-1:0] OP_SUB = 3'd1;
  localparam logic [OpW-1:0] OP_MUL = 3'd2;
  localparam logic [OpW-1:0] OP_DIV = 3'd3;
  localparam logic [OpW-1:0] OP_POW = 3'd4;
  localparam logic [OpW-1:0] OP_NEG = 3'd5;

  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_DIV_A,
    CMD_DIV_B,
    CMD_DIV_EU,
    CMD_DIV_STEP,
    CMD_MUL_AB,
    CMD_MUL_QV,
    CMD_MUL_AU,
    CMD_MUL_ACC,
    CMD_MUL_SQ,
    CMD_MUL_STEP,
    CMD_WB_A,
    CMD_WB_B,
    CMD_EU_INIT,
    CMD_EU_UPD,
    CMD_PW_INIT,
    CMD_PW_ACC,
    CMD_PW_SQ,
    CMD_SET_ARITH,
    CMD_SET_MUL,
    CMD_SET_POW,
    CMD_SET_ERR,
    CMD_EMIT
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RA,
    S_RA_RUN,
    S_RA_WB,
    S_RB,
    S_RB_RUN,
    S_RB_WB,
    S_DISP,
    S_M,
    S_M_RUN,
    S_SET_MUL,
    S_EU_INIT,
    S_EU_CHK,
    S_EU_D,
    S_EU_DRUN,
    S_EU_M,
    S_EU_MRUN,
    S_EU_UPD,
    S_EU_F,
    S_EU_FRUN,
    S_PW_INIT,
    S_PW_CHK,
    S_PW_A,
    S_PW_ARUN,
    S_PW_AWB,
    S_PW_S,
    S_PW_SRUN,
    S_PW_SWB,
    S_DONE
  } state_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic ea_zero;
    logic er_one;
    logic e_zero;
    logic e_lsb;
  } stat_t;

endpackage

// File: rtl/mau_datapath.sv
// Datapath: operand registers, serial divider and serial modular multiplier
`timescale 1ns / 1ps
module mau_datapath (
  input  logic                        clk_i,
  input  logic [mau_pkg::ModW-1:0]    mod_i,
  input  mau_pkg::ctrl_t              ctrl_i,
  input  logic [mau_pkg::OpW-1:0]     opcode_i,
  input  logic [mau_pkg::ValW-1:0]    operand_a_i,
  input  logic [mau_pkg::ValW-1:0]    operand_b_i,
  input  logic [mau_pkg::ExpW-1:0]    exponent_i,
  output mau_pkg::stat_t              stat_o,
  output logic [mau_pkg::ValW-1:0]    result_o,
  output logic                        error_o
);

  localparam int unsigned MW = mau_pkg::ModW;
  localparam int unsigned VW = mau_pkg::ValW;

  logic [mau_pkg::OpW-1:0]  op_q;
  logic [VW-1:0]            a_q, b_q, u_q, v_q, acc_q, x_q, ea_q, val_q, res_q;
  logic [MW-1:0]            er_q;
  logic [mau_pkg::ExpW-1:0] e_q;
  logic                     err_q, res_err_q;
  logic [MW-1:0]            dn_q, dd_q, dr_q, dq_q;
  logic [MW-1:0]            mx_q;
  logic [VW-1:0]            my_q, macc_q;

  logic [MW:0]   trial;
  logic          tge;
  logic [MW-1:0] dbl, dbl_r, sum, sum_r;
  logic [MW-1:0] ar_sum, ar_sub, ar_neg, nv;
  logic [VW-1:0] ar_val;
  logic [VW-1:0] one_m;

  always_comb begin
    trial = {dr_q, dn_q[MW-1]};
    tge   = trial >= {1'b0, dd_q};
    dbl   = {macc_q, 1'b0};
    dbl_r = (dbl >= mod_i) ? dbl - mod_i : dbl;
    sum   = dbl_r + (mx_q[MW-1] ? {1'b0, my_q} : '0);
    sum_r = (sum >= mod_i) ? sum - mod_i : sum;
    ar_sum = {1'b0, a_q} + {1'b0, b_q};
    if (ar_sum >= mod_i) begin
      ar_sum = ar_sum - mod_i;
    end
    ar_sub = (a_q >= b_q) ? {1'b0, a_q - b_q} : {1'b0, a_q} + mod_i - {1'b0, b_q};
    ar_neg = (a_q == '0) ? '0 : mod_i - {1'b0, a_q};
    case (op_q)
      mau_pkg::OP_ADD: ar_val = ar_sum[VW-1:0];
      mau_pkg::OP_SUB: ar_val = ar_sub[VW-1:0];
      mau_pkg::OP_NEG: ar_val = ar_neg[VW-1:0];
      default:         ar_val = '0;
    endcase
    nv = (u_q >= macc_q) ? {1'b0, u_q - macc_q} : {1'b0, u_q} + mod_i - {1'b0, macc_q};
    one_m = (mod_i == MW'(1)) ? '0 : VW'(1);
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      mau_pkg::CMD_LOAD: begin
        op_q <= opcode_i;
        a_q  <= operand_a_i;
        b_q  <= operand_b_i;
        e_q  <= exponent_i;
      end
      mau_pkg::CMD_DIV_A: begin
        dn_q <= {1'b0, a_q};
        dd_q <= mod_i;
        dr_q <= '0;
        dq_q <= '0;
      end
      mau_pkg::CMD_DIV_B: begin
        dn_q <= {1'b0, b_q};
        dd_q <= mod_i;
        dr_q <= '0;
        dq_q <= '0;
      end
      mau_pkg::CMD_DIV_EU: begin
        dn_q <= er_q;
        dd_q <= {1'b0, ea_q};
        dr_q <= '0;
        dq_q <= '0;
      end
      mau_pkg::CMD_DIV_STEP: begin
        dn_q <= {dn_q[MW-2:0], 1'b0};
        dr_q <= tge ? MW'(trial - {1'b0, dd_q}) : trial[MW-1:0];
        dq_q <= {dq_q[MW-2:0], tge};
      end
      mau_pkg::CMD_MUL_AB: begin
        mx_q <= {1'b0, a_q};
        my_q <= b_q;
        macc_q <= '0;
      end
      mau_pkg::CMD_MUL_QV: begin
        mx_q <= dq_q;
        my_q <= v_q;
        macc_q <= '0;
      end
      mau_pkg::CMD_MUL_AU: begin
        mx_q <= {1'b0, a_q};
        my_q <= u_q;
        macc_q <= '0;
      end
      mau_pkg::CMD_MUL_ACC: begin
        mx_q <= {1'b0, acc_q};
        my_q <= x_q;
        macc_q <= '0;
      end
      mau_pkg::CMD_MUL_SQ: begin
        mx_q <= {1'b0, x_q};
        my_q <= x_q;
        macc_q <= '0;
      end
      mau_pkg::CMD_MUL_STEP: begin
        mx_q <= {mx_q[MW-2:0], 1'b0};
        macc_q <= sum_r[VW-1:0];
      end
      mau_pkg::CMD_WB_A: a_q <= dr_q[VW-1:0];
      mau_pkg::CMD_WB_B: b_q <= dr_q[VW-1:0];
      mau_pkg::CMD_EU_INIT: begin
        er_q <= mod_i;
        ea_q <= b_q;
        u_q  <= '0;
        v_q  <= one_m;
      end
      mau_pkg::CMD_EU_UPD: begin
        er_q <= {1'b0, ea_q};
        ea_q <= dr_q[VW-1:0];
        u_q  <= v_q;
        v_q  <= nv[VW-1:0];
      end
      mau_pkg::CMD_PW_INIT: begin
        acc_q <= one_m;
        x_q   <= a_q;
      end
      mau_pkg::CMD_PW_ACC: acc_q <= macc_q;
      mau_pkg::CMD_PW_SQ: begin
        x_q <= macc_q;
        e_q <= {1'b0, e_q[mau_pkg::ExpW-1:1]};
      end
      mau_pkg::CMD_SET_ARITH: begin
        val_q <= ar_val;
        err_q <= 1'b0;
      end
      mau_pkg::CMD_SET_MUL: begin
        val_q <= macc_q;
        err_q <= 1'b0;
      end
      mau_pkg::CMD_SET_POW: begin
        val_q <= acc_q;
        err_q <= 1'b0;
      end
      mau_pkg::CMD_SET_ERR: begin
        val_q <= '0;
        err_q <= 1'b1;
      end
      mau_pkg::CMD_EMIT: begin
        res_q     <= val_q;
        res_err_q <= err_q;
      end
      default: ;
    endcase
  end

  assign stat_o.op      = op_q;
  assign stat_o.ea_zero = (ea_q == '0);
  assign stat_o.er_one  = (er_q == MW'(1));
  assign stat_o.e_zero  = (e_q == '0);
  assign stat_o.e_lsb   = e_q[0];
  assign result_o = res_q;
  assign error_o  = res_err_q;

endmodule

// File: rtl/mau_ctrl.sv
// Controller state machine sequencing the datapath for each item
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mau_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  mau_pkg::stat_t  stat_i,
  output mau_pkg::ctrl_t  ctrl_o
);

  mau_pkg::state_e state_q, state_d;
  logic [mau_pkg::CntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic emit;
  logic last;

  assign last = (cnt_q == mau_pkg::LastStep);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mau_pkg::S_IDLE:    if (in_valid_i) state_d = mau_pkg::S_RA;
      mau_pkg::S_RA:      state_d = mau_pkg::S_RA_RUN;
      mau_pkg::S_RA_RUN:  if (last) state_d = mau_pkg::S_RA_WB;
      mau_pkg::S_RA_WB:   state_d = mau_pkg::S_RB;
      mau_pkg::S_RB:      state_d = mau_pkg::S_RB_RUN;
      mau_pkg::S_RB_RUN:  if (last) state_d = mau_pkg::S_RB_WB;
      mau_pkg::S_RB_WB:   state_d = mau_pkg::S_DISP;
      mau_pkg::S_DISP: begin
        case (stat_i.op)
          mau_pkg::OP_MUL: state_d = mau_pkg::S_M;
          mau_pkg::OP_DIV: state_d = mau_pkg::S_EU_INIT;
          mau_pkg::OP_POW: state_d = mau_pkg::S_PW_INIT;
          default:         state_d = mau_pkg::S_DONE;
        endcase
      end
      mau_pkg::S_M:       state_d = mau_pkg::S_M_RUN;
      mau_pkg::S_M_RUN:   if (last) state_d = mau_pkg::S_SET_MUL;
      mau_pkg::S_SET_MUL: state_d = mau_pkg::S_DONE;
      mau_pkg::S_EU_INIT: state_d = mau_pkg::S_EU_CHK;
      mau_pkg::S_EU_CHK: begin
        if (!stat_i.ea_zero) begin
          state_d = mau_pkg::S_EU_D;
        end else if (stat_i.er_one) begin
          state_d = mau_pkg::S_EU_F;
        end else begin
          state_d = mau_pkg::S_DONE;
        end
      end
      mau_pkg::S_EU_D:    state_d = mau_pkg::S_EU_DRUN;
      mau_pkg::S_EU_DRUN: if (last) state_d = mau_pkg::S_EU_M;
      mau_pkg::S_EU_M:    state_d = mau_pkg::S_EU_MRUN;
      mau_pkg::S_EU_MRUN: if (last) state_d = mau_pkg::S_EU_UPD;
      mau_pkg::S_EU_UPD:  state_d = mau_pkg::S_EU_CHK;
      mau_pkg::S_EU_F:    state_d = mau_pkg::S_EU_FRUN;
      mau_pkg::S_EU_FRUN: if (last) state_d = mau_pkg::S_SET_MUL;
      mau_pkg::S_PW_INIT: state_d = mau_pkg::S_PW_CHK;
      mau_pkg::S_PW_CHK: begin
        if (stat_i.e_zero) begin
          state_d = mau_pkg::S_DONE;
        end else if (stat_i.e_lsb) begin
          state_d = mau_pkg::S_PW_A;
        end else begin
          state_d = mau_pkg::S_PW_S;
        end
      end
      mau_pkg::S_PW_A:    state_d = mau_pkg::S_PW_ARUN;
      mau_pkg::S_PW_ARUN: if (last) state_d = mau_pkg::S_PW_AWB;
      mau_pkg::S_PW_AWB:  state_d = mau_pkg::S_PW_S;
      mau_pkg::S_PW_S:    state_d = mau_pkg::S_PW_SRUN;
      mau_pkg::S_PW_SRUN: if (last) state_d = mau_pkg::S_PW_SWB;
      mau_pkg::S_PW_SWB:  state_d = mau_pkg::S_PW_CHK;
      mau_pkg::S_DONE:    if (!out_valid_q || out_ready_i) state_d = mau_pkg::S_IDLE;
      default:            state_d = mau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.cmd = mau_pkg::CMD_IDLE;
    in_ready_o = 1'b0;
    emit       = 1'b0;
    case (state_q)
      mau_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) ctrl_o.cmd = mau_pkg::CMD_LOAD;
      end
      mau_pkg::S_RA:      ctrl_o.cmd = mau_pkg::CMD_DIV_A;
      mau_pkg::S_RB:      ctrl_o.cmd = mau_pkg::CMD_DIV_B;
      mau_pkg::S_EU_D:    ctrl_o.cmd = mau_pkg::CMD_DIV_EU;
      mau_pkg::S_RA_RUN,
      mau_pkg::S_RB_RUN,
      mau_pkg::S_EU_DRUN: ctrl_o.cmd = mau_pkg::CMD_DIV_STEP;
      mau_pkg::S_M:       ctrl_o.cmd = mau_pkg::CMD_MUL_AB;
      mau_pkg::S_EU_M:    ctrl_o.cmd = mau_pkg::CMD_MUL_QV;
      mau_pkg::S_EU_F:    ctrl_o.cmd = mau_pkg::CMD_MUL_AU;
      mau_pkg::S_PW_A:    ctrl_o.cmd = mau_pkg::CMD_MUL_ACC;
      mau_pkg::S_PW_S:    ctrl_o.cmd = mau_pkg::CMD_MUL_SQ;
      mau_pkg::S_M_RUN,
      mau_pkg::S_EU_MRUN,
      mau_pkg::S_EU_FRUN,
      mau_pkg::S_PW_ARUN,
      mau_pkg::S_PW_SRUN: ctrl_o.cmd = mau_pkg::CMD_MUL_STEP;
      mau_pkg::S_RA_WB:   ctrl_o.cmd = mau_pkg::CMD_WB_A;
      mau_pkg::S_RB_WB:   ctrl_o.cmd = mau_pkg::CMD_WB_B;
      mau_pkg::S_DISP:    ctrl_o.cmd = mau_pkg::CMD_SET_ARITH;
      mau_pkg::S_SET_MUL: ctrl_o.cmd = mau_pkg::CMD_SET_MUL;
      mau_pkg::S_EU_INIT: ctrl_o.cmd = mau_pkg::CMD_EU_INIT;
      mau_pkg::S_EU_CHK:  ctrl_o.cmd = mau_pkg::CMD_SET_ERR;
      mau_pkg::S_EU_UPD:  ctrl_o.cmd = mau_pkg::CMD_EU_UPD;
      mau_pkg::S_PW_INIT: ctrl_o.cmd = mau_pkg::CMD_PW_INIT;
      mau_pkg::S_PW_CHK:  ctrl_o.cmd = mau_pkg::CMD_SET_POW;
      mau_pkg::S_PW_AWB:  ctrl_o.cmd = mau_pkg::CMD_PW_ACC;
      mau_pkg::S_PW_SWB:  ctrl_o.cmd = mau_pkg::CMD_PW_SQ;
      mau_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.cmd = mau_pkg::CMD_EMIT;
          emit       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (state_q)
      mau_pkg::S_RA_RUN, mau_pkg::S_RB_RUN, mau_pkg::S_EU_DRUN, mau_pkg::S_M_RUN,
      mau_pkg::S_EU_MRUN, mau_pkg::S_EU_FRUN, mau_pkg::S_PW_ARUN,
      mau_pkg::S_PW_SRUN: cnt_d = cnt_q + mau_pkg::CntW'(1);
      default:            cnt_d = '0;
    endcase
    out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mau_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= last ? '0 : cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_IMPLY(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= mau_pkg::LastStep, "step count overrun")
  `ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, emit, out_valid_q, "emitted item not valid")
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, state_q != mau_pkg::S_IDLE, "accepted item not started")
  `ASSERT_IMPLY(a_emit_free, clk_i, rst_ni, emit, !out_valid_q || out_ready_i, "result overwritten")

endmodule

// File: rtl/modular_arithmetic_unit.sv
// Top level of the modular arithmetic unit
`timescale 1ns / 1ps
// Computes one add, subtract, multiply, divide, power or negate modulo the
// configured modulus (reset 998244353) per item, one item at a time on a
// shared 1-bit-per-cycle divider and modular multiplier. Both operands are
// reduced first; add, subtract and negate then finish, multiply takes one
// multiplier pass, divide runs extended Euclid with a divide and a multiply
// per step and a final multiply if an inverse exists, and power squares per
// exponent bit and multiplies per set bit. A result waits in an output register while the
// next item is taken. Divide with no inverse gives 0 with the error flag set.
module modular_arithmetic_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [30:0]  cfg_data_i,     // modulus
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i, // opcode, operand_a, operand_b, exponent, zero pad
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [31:0]  m_axis_tdata_o, // result, zero pad
  output logic [0:0]   m_axis_tuser_o  // error
);

  logic [mau_pkg::ModW-1:0] mod_q, mod_eff;
  mau_pkg::ctrl_t ctrl;
  mau_pkg::stat_t stat;
  logic [mau_pkg::ValW-1:0] result;
  logic error;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= mau_pkg::ModReset;
    end else if (cfg_valid_i) begin
      mod_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (mod_q < mau_pkg::ModW'(2)) begin
      mod_eff = mau_pkg::ModW'(1);
    end else if (mod_q > mau_pkg::ModMax) begin
      mod_eff = mau_pkg::ModMax;
    end else begin
      mod_eff = mod_q;
    end
  end

  mau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  mau_datapath u_datapath (
    .clk_i       (clk_i),
    .mod_i       (mod_eff),
    .ctrl_i      (ctrl),
    .opcode_i    (s_axis_tdata_i[2:0]),
    .operand_a_i (s_axis_tdata_i[32:3]),
    .operand_b_i (s_axis_tdata_i[62:33]),
    .exponent_i  (s_axis_tdata_i[125:63]),
    .stat_o      (stat),
    .result_o    (result),
    .error_o     (error)
  );

  assign m_axis_tdata_o = {2'b00, result};
  assign m_axis_tuser_o = error;

endmodule
